### rtl/trss_pkg.sv
// ----------------------------------------------------------------------------
// trss_pkg
// Shared types and constants of the reply slot selector: event codes, basis
// codes, and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package trss_pkg;

  // Field widths
  localparam int FUNC_W  = 3;
  localparam int ADDR_W  = 16;
  localparam int DEV_W   = 32;
  localparam int UNITS_W = 8;
  localparam int SLOT_W  = 16;
  localparam int DELAY_W = 27;
  localparam int BASIS_W = 2;
  localparam int MS_W    = 11;

  // Event codes
  localparam logic [FUNC_W-1:0] FUNC_ADD_PREV = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD_CURR = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADD_DEV  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_WINDOW   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE  = 3'd4;

  // Basis codes
  localparam logic [BASIS_W-1:0] BASIS_ADDR = 2'd0;
  localparam logic [BASIS_W-1:0] BASIS_DEV  = 2'd1;
  localparam logic [BASIS_W-1:0] BASIS_NONE = 2'd2;

  localparam logic [SLOT_W-1:0] NO_SLOT = 16'hffff;

  // Slot register load source
  typedef enum logic [2:0] {
    SLOT_HOLD     = 3'd0,
    SLOT_ZERO     = 3'd1,
    SLOT_IDX_A    = 3'd2,
    SLOT_PREV_CNT = 3'd3,
    SLOT_BEST     = 3'd4
  } slot_op_t;

  typedef struct packed {
    logic                load;
    logic                set_window;
    logic                a_clr;
    logic                a_inc;
    logic                b_clr;
    logic                b_inc;
    logic                ins_write;
    logic                dev_mode;
    logic                best_clr;
    logic                best_upd;
    slot_op_t            slot_op;
    logic                basis_we;
    logic [BASIS_W-1:0]  basis;
    logic                clr_curr;
    logic                clr_dev;
    logic                mul;
    logic                load_out;
  } cmd_t;

  typedef struct packed {
    logic curr_zero;
    logic prev_zero;
    logic dev_zero;
    logic window_valid;
    logic sel_zero;
    logic ins_match;
    logic addr_match;
    logic a_last;
    logic b_last;
    logic out_free;
  } sts_t;

endpackage

### rtl/trss_req_if.sv
// ----------------------------------------------------------------------------
// trss_req_if
// Event channel: valid/ready handshake with the event payload.
// ----------------------------------------------------------------------------
interface trss_req_if import trss_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [ADDR_W-1:0]  address;
  logic [DEV_W-1:0]   device_id;
  logic [UNITS_W-1:0] init_units;
  logic [UNITS_W-1:0] slot_units;

  modport source (
    output valid, func, address, device_id, init_units, slot_units,
    input  ready
  );

  modport sink (
    input  valid, func, address, device_id, init_units, slot_units,
    output ready
  );

endinterface

### rtl/trss_rsp_if.sv
// ----------------------------------------------------------------------------
// trss_rsp_if
// Result channel: valid/ready handshake with the chosen slot and delay.
// ----------------------------------------------------------------------------
interface trss_rsp_if import trss_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  slot_index;
  logic [DELAY_W-1:0] delay_ms;
  logic [BASIS_W-1:0] basis;

  modport source (
    output valid, slot_index, delay_ms, basis,
    input  ready
  );

  modport sink (
    input  valid, slot_index, delay_ms, basis,
    output ready
  );

endinterface

### rtl/tdma_reply_slot_selector_top.sv
// ----------------------------------------------------------------------------
// tdma_reply_slot_selector_top
// Reply timeslot selector for a slotted radio link.
// ----------------------------------------------------------------------------
// Events arrive on req (valid/ready): add a previous-round address, add a
// current address, add a device id, set the window, or compute. Only compute
// produces a transfer on rsp: slot_index, delay_ms and basis.
// Events are handled one at a time; req.ready is high only while idle.
// Work per event:
//   window or unused code: handled in the idle state
//   list add: straight to the append into an empty list, else a duplicate scan
//     over the entries already in the list, one entry per read and check
//     through the registered memory read; a duplicate ends the scan early
//   compute, address basis: in the worst case every previous-round and
//     current address pair, one address pair per read and check
//   compute, device basis: one pass over the device ids
//   compute, no basis: straight to the multiply and the result load
// The result sits in an output register; the next event is taken while it
// waits. A compute that finishes while that register is still full holds
// until rsp.ready frees it. Reset empties all lists, clears the window and
// drops any pending result; there is no clearing pass.
// ----------------------------------------------------------------------------
module tdma_reply_slot_selector_top import trss_pkg::*; #(
  parameter int LIST_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  trss_req_if.sink   req,
  trss_rsp_if.source rsp
);

  cmd_t cmd;
  sts_t sts;
  logic ready;

  assign req.ready = ready;

  // Sequencer
  trss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_func  (req.func),
    .in_ready (ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Storage and arithmetic
  trss_dpath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .req_func       (req.func),
    .req_address    (req.address),
    .req_device_id  (req.device_id),
    .req_init_units (req.init_units),
    .req_slot_units (req.slot_units),
    .rsp            (rsp)
  );

endmodule

### rtl/trss_dpath.sv
// ----------------------------------------------------------------------------
// trss_dpath
// Datapath: the three lists in memories, their counts, scan counters, the
// window registers, the minimum tracker, the delay multiplier and the result
// register.
// ----------------------------------------------------------------------------
module trss_dpath import trss_pkg::*; #(
  parameter int LIST_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [FUNC_W-1:0]  req_func,
  input  logic [ADDR_W-1:0]  req_address,
  input  logic [DEV_W-1:0]   req_device_id,
  input  logic [UNITS_W-1:0] req_init_units,
  input  logic [UNITS_W-1:0] req_slot_units,
  trss_rsp_if.source         rsp
);

  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  typedef enum logic [1:0] {
    LIST_PREV = 2'd0,
    LIST_CURR = 2'd1,
    LIST_DEV  = 2'd2
  } list_t;

  // Latched event
  logic [FUNC_W-1:0] func_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DEV_W-1:0]  dev_q;

  // List storage
  logic [ADDR_W-1:0] prev_mem [LIST_DEPTH];
  logic [ADDR_W-1:0] curr_mem [LIST_DEPTH];
  logic [DEV_W-1:0]  dev_mem  [LIST_DEPTH];
  logic [ADDR_W-1:0] prev_rd;
  logic [ADDR_W-1:0] curr_rd;
  logic [DEV_W-1:0]  dev_rd;
  logic [CW-1:0]     prev_count;
  logic [CW-1:0]     curr_count;
  logic [CW-1:0]     dev_count;

  // Scan counters
  logic [CW-1:0] idx_a;
  logic [CW-1:0] idx_b;
  logic [CW-1:0] curr_raddr;

  // Window
  logic [DEV_W-1:0] window_base;
  logic             window_valid;
  logic [MS_W-1:0]  init_ms;
  logic [MS_W-1:0]  slot_ms;

  // Slot selection and result
  logic signed [DEV_W-1:0] best;
  logic signed [DEV_W-1:0] diff;
  logic [SLOT_W-1:0]       slot;
  logic [BASIS_W-1:0]      basis;
  logic [DELAY_W-1:0]      prod;
  logic                    out_valid;
  logic [SLOT_W-1:0]       out_slot;
  logic [DELAY_W-1:0]      out_delay;
  logic [BASIS_W-1:0]      out_basis;

  list_t         sel;
  logic [CW-1:0] cnt_sel;
  logic          ins_match;
  logic          we_prev;
  logic          we_curr;
  logic          we_dev;

  // Pick the list the current operation works on
  always_comb begin
    if (func_q == FUNC_ADD_CURR) begin
      sel = LIST_CURR;
    end else if (func_q == FUNC_ADD_DEV || cmd.dev_mode) begin
      sel = LIST_DEV;
    end else begin
      sel = LIST_PREV;
    end
  end

  always_comb begin
    case (sel)
      LIST_PREV: begin
        cnt_sel   = prev_count;
        ins_match = (prev_rd == addr_q);
      end
      LIST_CURR: begin
        cnt_sel   = curr_count;
        ins_match = (curr_rd == addr_q);
      end
      LIST_DEV: begin
        cnt_sel   = dev_count;
        ins_match = (dev_rd == dev_q);
      end
      default: begin
        cnt_sel   = prev_count;
        ins_match = 1'b0;
      end
    endcase
  end

  assign sts.ins_match    = ins_match;
  assign sts.curr_zero    = (curr_count == '0);
  assign sts.prev_zero    = (prev_count == '0);
  assign sts.dev_zero     = (dev_count == '0);
  assign sts.window_valid = window_valid;
  assign sts.sel_zero     = (cnt_sel == '0);
  assign sts.addr_match   = (prev_rd == curr_rd);
  assign sts.a_last       = ((CW+1)'(idx_a) + (CW+1)'(1)) >= (CW+1)'(cnt_sel);
  assign sts.b_last       = ((CW+1)'(idx_b) + (CW+1)'(1)) >= (CW+1)'(curr_count);
  assign sts.out_free     = !out_valid || rsp.ready;

  // Latch the event payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_q <= req_address;
      dev_q  <= req_device_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      func_q <= FUNC_ADD_PREV;
    end else if (cmd.load) begin
      func_q <= req_func;
    end
  end

  // Append only while the list has room
  assign we_prev = cmd.ins_write && (sel == LIST_PREV) && (prev_count < CW'(LIST_DEPTH));
  assign we_curr = cmd.ins_write && (sel == LIST_CURR) && (curr_count < CW'(LIST_DEPTH));
  assign we_dev  = cmd.ins_write && (sel == LIST_DEV) && (dev_count < CW'(LIST_DEPTH));

  assign curr_raddr = (func_q == FUNC_ADD_CURR) ? idx_a : idx_b;

  // List memories, registered reads
  always_ff @(posedge clk) begin
    if (we_prev) begin
      prev_mem[prev_count[IW-1:0]] <= addr_q;
    end
    prev_rd <= prev_mem[idx_a[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we_curr) begin
      curr_mem[curr_count[IW-1:0]] <= addr_q;
    end
    curr_rd <= curr_mem[curr_raddr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we_dev) begin
      dev_mem[dev_count[IW-1:0]] <= dev_q;
    end
    dev_rd <= dev_mem[idx_a[IW-1:0]];
  end

  // Counts
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_count <= '0;
      curr_count <= '0;
      dev_count  <= '0;
    end else begin
      if (we_prev) begin
        prev_count <= prev_count + CW'(1);
      end
      if (cmd.clr_curr) begin
        curr_count <= '0;
      end else if (we_curr) begin
        curr_count <= curr_count + CW'(1);
      end
      if (cmd.clr_dev) begin
        dev_count <= '0;
      end else if (we_dev) begin
        dev_count <= dev_count + CW'(1);
      end
    end
  end

  // Scan counters
  always_ff @(posedge clk) begin
    if (rst) begin
      idx_a <= '0;
      idx_b <= '0;
    end else begin
      if (cmd.a_clr) begin
        idx_a <= '0;
      end else if (cmd.a_inc) begin
        idx_a <= idx_a + CW'(1);
      end
      if (cmd.b_clr) begin
        idx_b <= '0;
      end else if (cmd.b_inc) begin
        idx_b <= idx_b + CW'(1);
      end
    end
  end

  // Window: lengths scaled by five as shift and add
  always_ff @(posedge clk) begin
    if (rst) begin
      window_base  <= '0;
      window_valid <= 1'b0;
      init_ms      <= '0;
      slot_ms      <= '0;
    end else if (cmd.set_window) begin
      window_base  <= req_device_id;
      window_valid <= 1'b1;
      init_ms      <= (MS_W'(req_init_units) << 2) + MS_W'(req_init_units);
      slot_ms      <= (MS_W'(req_slot_units) << 2) + MS_W'(req_slot_units);
    end else if (cmd.clr_dev) begin
      window_base  <= '0;
      window_valid <= 1'b0;
    end
  end

  // Track the smallest signed offset from the window base
  assign diff = $signed(dev_rd - window_base);

  always_ff @(posedge clk) begin
    if (cmd.best_clr) begin
      best <= $signed(DEV_W'(NO_SLOT));
    end else if (cmd.best_upd && (diff < best)) begin
      best <= diff;
    end
  end

  // Slot and basis
  always_ff @(posedge clk) begin
    case (cmd.slot_op)
      SLOT_ZERO:     slot <= '0;
      SLOT_IDX_A:    slot <= SLOT_W'(idx_a);
      SLOT_PREV_CNT: slot <= SLOT_W'(prev_count);
      SLOT_BEST: begin
        if (best == $signed(DEV_W'(NO_SLOT)) || best < 0) begin
          slot <= '0;
        end else begin
          slot <= best[SLOT_W-1:0];
        end
      end
      default:       slot <= slot;
    endcase
    if (cmd.basis_we) begin
      basis <= cmd.basis;
    end
  end

  // Slot length times slot, registered before the add
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= DELAY_W'(slot_ms) * DELAY_W'(slot);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_slot  <= slot;
      out_delay <= DELAY_W'(init_ms) + prod;
      out_basis <= basis;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.slot_index = out_slot;
  assign rsp.delay_ms   = out_delay;
  assign rsp.basis      = out_basis;

  // Checks
  a_prev_bound: assert property (@(posedge clk) disable iff (rst)
    prev_count <= CW'(LIST_DEPTH))
    else $error("previous-round count beyond list depth");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    idx_a <= CW'(LIST_DEPTH - 1) && idx_b <= CW'(LIST_DEPTH - 1))
    else $error("scan index beyond list depth");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result load did not raise valid");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_basis == BASIS_NONE |-> out_slot == '0)
    else $error("slot not zero without a basis");

  a_addr_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_basis == BASIS_ADDR |-> out_slot <= SLOT_W'(prev_count))
    else $error("address slot beyond previous-round count");

endmodule

### rtl/trss_ctrl.sv
// ----------------------------------------------------------------------------
// trss_ctrl
// Controller: accepts events, sequences duplicate scans, the pairwise
// address match, the device offset scan and the delay calculation.
// ----------------------------------------------------------------------------
module trss_ctrl import trss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [FUNC_W-1:0] in_func,
  output logic              in_ready,
  output cmd_t              cmd,
  input  sts_t              sts
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_INS_RD  = 11'b000_0000_0010,
    S_INS_CHK = 11'b000_0000_0100,
    S_INS_WR  = 11'b000_0000_1000,
    S_CMP_RD  = 11'b000_0001_0000,
    S_CMP_CHK = 11'b000_0010_0000,
    S_DEV_RD  = 11'b000_0100_0000,
    S_DEV_CHK = 11'b000_1000_0000,
    S_DEV_FIN = 11'b001_0000_0000,
    S_MUL     = 11'b010_0000_0000,
    S_OUT     = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.slot_op = SLOT_HOLD;
    cmd.basis   = BASIS_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cmd.a_clr = 1'b1;
          cmd.b_clr = 1'b1;
          case (in_func)
            FUNC_ADD_PREV, FUNC_ADD_CURR, FUNC_ADD_DEV: begin
              state_next = S_INS_RD;
            end
            FUNC_WINDOW: begin
              cmd.set_window = 1'b1;
            end
            FUNC_COMPUTE: begin
              cmd.basis_we = 1'b1;
              if (!sts.curr_zero) begin
                cmd.basis = BASIS_ADDR;
                if (sts.prev_zero) begin
                  cmd.slot_op  = SLOT_PREV_CNT;
                  cmd.clr_curr = 1'b1;
                  state_next   = S_MUL;
                end else begin
                  state_next = S_CMP_RD;
                end
              end else if (sts.window_valid) begin
                cmd.basis    = BASIS_DEV;
                cmd.best_clr = 1'b1;
                state_next   = sts.dev_zero ? S_DEV_FIN : S_DEV_RD;
              end else begin
                cmd.basis   = BASIS_NONE;
                cmd.slot_op = SLOT_ZERO;
                state_next  = S_MUL;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      // Duplicate scan over the selected list
      S_INS_RD: begin
        state_next = sts.sel_zero ? S_INS_WR : S_INS_CHK;
      end
      S_INS_CHK: begin
        if (sts.ins_match) begin
          state_next = S_IDLE;
        end else if (sts.a_last) begin
          state_next = S_INS_WR;
        end else begin
          cmd.a_inc  = 1'b1;
          state_next = S_INS_RD;
        end
      end
      S_INS_WR: begin
        cmd.ins_write = 1'b1;
        state_next    = S_IDLE;
      end
      // Previous-round index outer, current list inner
      S_CMP_RD: begin
        state_next = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (sts.addr_match) begin
          cmd.slot_op  = SLOT_IDX_A;
          cmd.clr_curr = 1'b1;
          state_next   = S_MUL;
        end else if (!sts.b_last) begin
          cmd.b_inc  = 1'b1;
          state_next = S_CMP_RD;
        end else if (!sts.a_last) begin
          cmd.a_inc  = 1'b1;
          cmd.b_clr  = 1'b1;
          state_next = S_CMP_RD;
        end else begin
          cmd.slot_op  = SLOT_PREV_CNT;
          cmd.clr_curr = 1'b1;
          state_next   = S_MUL;
        end
      end
      // Device offset minimum
      S_DEV_RD: begin
        cmd.dev_mode = 1'b1;
        state_next   = S_DEV_CHK;
      end
      S_DEV_CHK: begin
        cmd.dev_mode = 1'b1;
        cmd.best_upd = 1'b1;
        if (sts.a_last) begin
          state_next = S_DEV_FIN;
        end else begin
          cmd.a_inc  = 1'b1;
          state_next = S_DEV_RD;
        end
      end
      S_DEV_FIN: begin
        cmd.dev_mode = 1'b1;
        cmd.slot_op  = SLOT_BEST;
        cmd.clr_dev  = 1'b1;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_OUT;
      end
      // Hold until the result register is free
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Checks
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && !sts.out_free |=> state == S_OUT)
    else $error("pending result dropped while output busy");

  a_mul_next: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |=> state == S_OUT)
    else $error("multiply not followed by result load");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_func == FUNC_COMPUTE |=> !in_ready)
    else $error("compute event finished without a result");

endmodule
